/* hw/rtl/darcy_weisbach_semi_implicit_update_assert.svh */
// Assertion macros for the friction update block.
`ifndef DARCY_WEISBACH_SEMI_IMPLICIT_UPDATE_ASSERT_SVH
`define DARCY_WEISBACH_SEMI_IMPLICIT_UPDATE_ASSERT_SVH

// same-cycle implication, reset-qualified
`define DWSI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dwsi: same-cycle check failed");

// next-cycle implication, reset-qualified
`define DWSI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dwsi: next-cycle check failed");

`endif

/* hw/rtl/dwsi_pkg.sv */
// Shared types and constants of the friction update block.
`default_nettype none
package dwsi_pkg;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;
    localparam logic [31:0] K_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] depth;
        logic [31:0] flow_x;
        logic [31:0] flow_y;
        logic [31:0] fric;
        logic [31:0] ts;
    } cell_t;
endpackage
`default_nettype wire

/* hw/rtl/darcy_weisbach_semi_implicit_update.sv */
// Semi-implicit Darcy-Weisbach friction update, fully pipelined.
//   channel | signals                                        | dir
//   in      | in_valid, in_stall, vel_x..fric_coef           | cell in
//   out     | out_valid, out_stall, flow_x_out..damp_saturated| result out
//   cfg     | cfg_valid, cfg_ready, cfg_data                 | time_step write
// One cell per cycle unless out_stall holds the pipeline; its depth is set by the
// 32-step square root and the two 32-step restoring dividers, one bit per stage.
// rst_n clears valid bits and time_step; payload registers are not reset.
// out_stall with a valid result freezes every stage and raises in_stall.
`default_nettype none
module darcy_weisbach_semi_implicit_update #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] vel_x,
    input  wire logic [31:0] vel_y,
    input  wire logic [31:0] depth,
    input  wire logic [31:0] flow_x,
    input  wire logic [31:0] flow_y,
    input  wire logic [31:0] fric_coef,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      flow_x_out,
    output logic [31:0]      flow_y_out,
    output logic             dry_cell,
    output logic             damp_saturated,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);
    localparam int SH  = FRAC_BITS + 3;
    localparam int HIW = 64 - SH;
    localparam int NSQ = dwsi_pkg::SQRT_STEPS;
    localparam int NDV = dwsi_pkg::DIV_STEPS;
    // stage map: 0 capture, 1 squares, 2 sum, sqrt, fs, partials, product,
    // div init, div, den, div2, output
    localparam int ST_SQ0 = 2;
    localparam int ST_FS  = ST_SQ0 + NSQ + 1;
    localparam int ST_AB  = ST_FS + 1;
    localparam int ST_P   = ST_AB + 1;
    localparam int ST_DV0 = ST_P + 1;
    localparam int ST_DN  = ST_DV0 + NDV + 1;
    localparam int ST_OUT = ST_DN + NDV + 1;
    localparam int NST    = ST_OUT + 1;

    logic        adv;
    logic [31:0] time_step_reg;
    logic        vld_reg [NST];

    assign cfg_ready = 1'b1;
    assign adv       = !(vld_reg[ST_OUT] && out_stall);
    assign in_stall  = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            time_step_reg <= '0;
        else if (cfg_valid)
            time_step_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // capture, magnitudes
    logic [31:0]     ux_reg, uy_reg;
    dwsi_pkg::cell_t pay0_reg, pay1_reg;
    logic [63:0]     ux2_reg, uy2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ux_reg         <= vel_x[31] ? (~vel_x + 32'd1) : vel_x;
            uy_reg         <= vel_y[31] ? (~vel_y + 32'd1) : vel_y;
            pay0_reg.depth <= depth;
            pay0_reg.flow_x <= flow_x;
            pay0_reg.flow_y <= flow_y;
            pay0_reg.fric  <= fric_coef;
            pay0_reg.ts    <= time_step_reg;
            ux2_reg        <= ux_reg * ux_reg;
            uy2_reg        <= uy_reg * uy_reg;
            pay1_reg       <= pay0_reg;
        end
    end

    // square root, one result bit per stage
    logic [32:0]     sq_rem_reg  [NSQ+1];
    logic [31:0]     sq_root_reg [NSQ+1];
    logic [63:0]     sq_rad_reg  [NSQ+1];
    dwsi_pkg::cell_t sq_pay_reg  [NSQ+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_rad_reg[0]  <= ux2_reg + uy2_reg;
            sq_pay_reg[0]  <= pay1_reg;
        end
    end

    for (genvar j = 0; j < NSQ; j++)
    begin : g_sqrt
        logic [34:0] rem_sh, trial;
        logic        ge;
        logic [32:0] rem_next;
        logic [31:0] root_next;

        always_comb
        begin
            rem_sh    = {sq_rem_reg[j], sq_rad_reg[j][63:62]};
            trial     = {1'b0, sq_root_reg[j], 2'b01};
            ge        = rem_sh >= trial;
            rem_next  = ge ? 33'(rem_sh - trial) : rem_sh[32:0];
            root_next = {sq_root_reg[j][30:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[j+1]  <= rem_next;
                sq_root_reg[j+1] <= root_next;
                sq_rad_reg[j+1]  <= {sq_rad_reg[j][61:0], 2'b00};
                sq_pay_reg[j+1]  <= sq_pay_reg[j];
            end
        end
    end

    // f * speed * dt
    logic [63:0]     fs_reg, pa_reg, pb_reg;
    logic [95:0]     prod_reg;
    dwsi_pkg::cell_t fs_pay_reg, ab_pay_reg, p_pay_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fs_reg     <= sq_pay_reg[NSQ].fric * sq_root_reg[NSQ];
            fs_pay_reg <= sq_pay_reg[NSQ];
            pa_reg     <= fs_reg[31:0] * fs_pay_reg.ts;
            pb_reg     <= fs_reg[63:32] * fs_pay_reg.ts;
            ab_pay_reg <= fs_pay_reg;
            prod_reg   <= {32'd0, pa_reg} + {pb_reg, 32'd0};
            p_pay_reg  <= ab_pay_reg;
        end
    end

    // k = floor((P >> SH) / depth); saturates when the high word reaches depth
    logic [HIW-1:0] p_hi;
    logic           sat_next;

    assign p_hi     = prod_reg[95:SH+32];
    assign sat_next = p_hi >= {{(HIW-32){1'b0}}, p_pay_reg.depth};

    logic [31:0] dv_rem_reg [NDV+1];
    logic [31:0] dv_q_reg   [NDV+1];
    logic [31:0] dv_low_reg [NDV+1];
    logic [31:0] dv_h_reg   [NDV+1];
    logic [31:0] dv_fx_reg  [NDV+1];
    logic [31:0] dv_fy_reg  [NDV+1];
    logic        dv_sat_reg [NDV+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_rem_reg[0] <= sat_next ? 32'd0 : p_hi[31:0];
            dv_q_reg[0]   <= '0;
            dv_low_reg[0] <= prod_reg[SH+31:SH];
            dv_h_reg[0]   <= p_pay_reg.depth;
            dv_fx_reg[0]  <= p_pay_reg.flow_x;
            dv_fy_reg[0]  <= p_pay_reg.flow_y;
            dv_sat_reg[0] <= sat_next;
        end
    end

    for (genvar j = 0; j < NDV; j++)
    begin : g_div
        logic [32:0] rem_sh;
        logic        ge;
        logic [31:0] rem_next;

        always_comb
        begin
            rem_sh   = {dv_rem_reg[j], dv_low_reg[j][31]};
            ge       = rem_sh >= {1'b0, dv_h_reg[j]};
            rem_next = ge ? 32'(rem_sh - {1'b0, dv_h_reg[j]}) : rem_sh[31:0];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[j+1] <= rem_next;
                dv_q_reg[j+1]   <= {dv_q_reg[j][30:0], ge};
                dv_low_reg[j+1] <= {dv_low_reg[j][30:0], 1'b0};
                dv_h_reg[j+1]   <= dv_h_reg[j];
                dv_fx_reg[j+1]  <= dv_fx_reg[j];
                dv_fy_reg[j+1]  <= dv_fy_reg[j];
                dv_sat_reg[j+1] <= dv_sat_reg[j];
            end
        end
    end

    // flow * 2^FRAC_BITS / (2^FRAC_BITS + k), two lanes on magnitudes
    logic [31:0] k_val, mx, my;
    logic [32:0] den_next;

    assign k_val    = dv_sat_reg[NDV] ? dwsi_pkg::K_MAX : dv_q_reg[NDV];
    assign den_next = {1'b0, k_val} + (33'd1 << FRAC_BITS);
    assign mx = dv_fx_reg[NDV][31] ? (~dv_fx_reg[NDV] + 32'd1) : dv_fx_reg[NDV];
    assign my = dv_fy_reg[NDV][31] ? (~dv_fy_reg[NDV] + 32'd1) : dv_fy_reg[NDV];

    logic [32:0] ln_rem_reg [2][NDV+1];
    logic [31:0] ln_q_reg   [2][NDV+1];
    logic [31:0] ln_low_reg [2][NDV+1];
    logic [32:0] ln_den_reg [NDV+1];
    logic        ln_negx_reg[NDV+1];
    logic        ln_negy_reg[NDV+1];
    logic        ln_dry_reg [NDV+1];
    logic        ln_sat_reg [NDV+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ln_rem_reg[0][0] <= {{(33-FRAC_BITS){1'b0}}, mx[31:32-FRAC_BITS]};
            ln_rem_reg[1][0] <= {{(33-FRAC_BITS){1'b0}}, my[31:32-FRAC_BITS]};
            ln_low_reg[0][0] <= {mx[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
            ln_low_reg[1][0] <= {my[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
            ln_q_reg[0][0]   <= '0;
            ln_q_reg[1][0]   <= '0;
            ln_den_reg[0]    <= den_next;
            ln_negx_reg[0]   <= dv_fx_reg[NDV][31];
            ln_negy_reg[0]   <= dv_fy_reg[NDV][31];
            ln_dry_reg[0]    <= dv_h_reg[NDV] == 32'd0;
            ln_sat_reg[0]    <= dv_sat_reg[NDV];
        end
    end

    for (genvar j = 0; j < NDV; j++)
    begin : g_div2
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ln_den_reg[j+1]  <= ln_den_reg[j];
                ln_negx_reg[j+1] <= ln_negx_reg[j];
                ln_negy_reg[j+1] <= ln_negy_reg[j];
                ln_dry_reg[j+1]  <= ln_dry_reg[j];
                ln_sat_reg[j+1]  <= ln_sat_reg[j];
            end
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [33:0] rem_sh;
            logic        ge;
            logic [32:0] rem_next;

            always_comb
            begin
                rem_sh   = {ln_rem_reg[l][j], ln_low_reg[l][j][31]};
                ge       = rem_sh >= {1'b0, ln_den_reg[j]};
                rem_next = ge ? 33'(rem_sh - {1'b0, ln_den_reg[j]}) : rem_sh[32:0];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ln_rem_reg[l][j+1] <= rem_next;
                    ln_q_reg[l][j+1]   <= {ln_q_reg[l][j][30:0], ge};
                    ln_low_reg[l][j+1] <= {ln_low_reg[l][j][30:0], 1'b0};
                end
            end
        end
    end

    // output register: sign restore, dry cell forces zero
    logic [31:0] fxo_reg, fyo_reg;
    logic        dry_reg, sat_reg;
    logic [31:0] rx, ry;

    assign rx = ln_q_reg[0][NDV];
    assign ry = ln_q_reg[1][NDV];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fxo_reg <= ln_dry_reg[NDV] ? 32'd0 : (ln_negx_reg[NDV] ? (~rx + 32'd1) : rx);
            fyo_reg <= ln_dry_reg[NDV] ? 32'd0 : (ln_negy_reg[NDV] ? (~ry + 32'd1) : ry);
            dry_reg <= ln_dry_reg[NDV];
            sat_reg <= ln_sat_reg[NDV] && !ln_dry_reg[NDV];
        end
    end

    assign out_valid      = vld_reg[ST_OUT];
    assign flow_x_out     = fxo_reg;
    assign flow_y_out     = fyo_reg;
    assign dry_cell       = dry_reg;
    assign damp_saturated = sat_reg;

`include "darcy_weisbach_semi_implicit_update_assert.svh"

    `DWSI_ASSERT_IMP(a_dry_zero, out_valid && dry_cell,
        flow_x_out == 32'd0 && flow_y_out == 32'd0 && !damp_saturated)
    `DWSI_ASSERT_NXT(a_hold_on_stall, in_stall, out_valid)
    `DWSI_ASSERT_IMP(a_stall_src, in_stall, out_valid && out_stall)

endmodule
`default_nettype wire
